// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge of clk, muted while arst_n is low.
`define ASSERT_CLK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hw/rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int RAW_W    = 24;
	localparam int VAL_W    = 21;
	localparam int CFG_W    = 32;
	localparam int CFG_NUM  = 8;
	localparam int CFG_IDX_W = $clog2(CFG_NUM);

	localparam logic [CFG_IDX_W-1:0] CFG_AC1    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AC2    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AC3    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_AC4    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_AC5AC6 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_B1B2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MCMD   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OSS    = 3'd7;

	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
	localparam logic signed [31:0] B4_OFFSET  = 32'sd32768;
	localparam logic [31:0]        B7_SCALE   = 32'd50000;
	localparam logic [31:0]        B7_TOPBIT  = 32'h8000_0000;
	localparam logic signed [31:0] P_C1       = 32'sd3038;
	localparam logic signed [31:0] P_C2       = -32'sd7357;
	localparam logic signed [31:0] P_C3       = 32'sd3791;
	localparam logic signed [31:0] OUT_MAX    = 32'sd1048575;
	localparam logic signed [31:0] OUT_MIN    = -32'sd1048576;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T1,
		ST_T2,
		ST_TFIN,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_P6,
		ST_P7,
		ST_P8,
		ST_DIV,
		ST_PQ,
		ST_P9,
		ST_P10,
		ST_P11,
		ST_DONE
	} bpc_state_t;

endpackage

// ----- hw/rtl/bpc_in_if.sv -----
// ----------------------------------------------------------------------------
// bpc_in_if
// Input channel: raw reading and its kind, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bpc_in_if
	import bpc_pkg::*;
;
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [RAW_W-1:0] raw_reading;

	modport source (output valid, output cmd, output raw_reading, input ready);
	modport sink   (input valid, input cmd, input raw_reading, output ready);
endinterface

// ----- hw/rtl/bpc_out_if.sv -----
// ----------------------------------------------------------------------------
// bpc_out_if
// Output channel: compensated value, kind and error flag, valid/ready.
// ----------------------------------------------------------------------------
interface bpc_out_if
	import bpc_pkg::*;
;
	logic                    valid;
	logic                    ready;
	logic                    reading_kind;
	logic signed [VAL_W-1:0] compensated_value;
	logic                    math_error;

	modport source (output valid, output reading_kind, output compensated_value,
		output math_error, input ready);
	modport sink   (input valid, input reading_kind, input compensated_value,
		input math_error, output ready);
endinterface

// ----- hw/rtl/barometric_pressure_compensation.sv -----
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Integer calibration of raw temperature and pressure readings with one
// shared 32-bit multiplier and a radix-2 divider under a small sequencer.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    cmd, raw_reading
//   out_ch   out  valid/ready    reading_kind, compensated_value, math_error
//   cfg      in   cfg_we         cfg_idx, cfg_wdata
//
// A temperature transaction and a pressure transaction each run through the
// divider's 32 one-bit steps; a zero B4 or a zero temperature divisor skips
// the divider, and each sequencer state uses the multiplier at most once.
// One transaction in flight; in_ch.ready is high only while idle.
// A finished result waits in the output register; a second result waits in
// the last state until that register frees up.
// Reset clears the sequencer, the kept B5 and all coefficients.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module barometric_pressure_compensation
	import bpc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	bpc_in_if.sink               in_ch,
	bpc_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	bpc_state_t state_q, state_d;

	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q;
	logic [31:0] ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	logic              cmd_q, err_q, big_q, neg_q;
	logic [RAW_W-1:0]  raw_q;
	logic signed [31:0] b5_q, x1_q, t1_q, sq_q, b3_q, p_q, res_q;
	logic [31:0]       b4_q, dden_q, rem_q, quo_q;
	logic [4:0]        cnt_q;

	logic                    out_valid_q;
	logic                    out_kind_q;
	logic signed [VAL_W-1:0] out_val_q;
	logic                    out_err_q;

	logic in_fire, out_free;
	assign in_fire  = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);

	// Coefficient views
	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md, b6;
	logic [31:0] ac4, ac5, ac6, ut, up;
	assign ac1 = {{16{ac1_q[15]}}, ac1_q};
	assign ac2 = {{16{ac2_q[15]}}, ac2_q};
	assign ac3 = {{16{ac3_q[15]}}, ac3_q};
	assign ac4 = {16'd0, ac4_q};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
	assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
	assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
	assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};
	assign b6  = b5_q - B6_OFFSET;
	assign ut  = {16'd0, raw_q[15:0]};
	assign up  = {8'd0, raw_q} >> (4'd8 - {2'd0, oss_q});

	// Shared multiplier, low 32 bits of the product
	logic [31:0] ma, mb, prod;
	logic signed [31:0] sprod;
	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			ST_T1: begin ma = ut - ac6; mb = ac5; end
			ST_P1: begin ma = b6; mb = b6; end
			ST_P2: begin ma = b2; mb = sq_q; end
			ST_P3: begin ma = ac2; mb = b6; end
			ST_P4: begin ma = (ac1 <<< 2) + t1_q; mb = 32'd1 << oss_q; end
			ST_P5: begin ma = ac3; mb = b6; end
			ST_P6: begin ma = b1; mb = sq_q; end
			ST_P7: begin ma = ac4; mb = t1_q + B4_OFFSET; end
			ST_P8: begin ma = up - b3_q; mb = B7_SCALE >> oss_q; end
			ST_P9: begin ma = p_q >>> 8; mb = p_q >>> 8; end
			ST_P10: begin ma = t1_q; mb = P_C1; end
			ST_P11: begin ma = P_C2; mb = p_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod  = ma * mb;
	assign sprod = prod;

	// Temperature divisor and dividend
	logic signed [31:0] den, mc_sh;
	assign den   = x1_q + md;
	assign mc_sh = mc <<< 11;

	// Divider step
	logic [32:0] rem_sh;
	logic        ge;
	assign rem_sh = {rem_q, quo_q[31]};
	assign ge     = rem_sh >= {1'b0, dden_q};

	logic signed [31:0] x2_t, b5_t;
	assign x2_t = neg_q ? -quo_q : quo_q;
	assign b5_t = x1_q + x2_t;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire) begin
				state_d = (in_ch.cmd == CMD_PRESS) ? ST_P1 : ST_T1;
			end
			ST_T1:  state_d = ST_T2;
			ST_T2:  state_d = (den == 0) ? ST_TFIN : ST_DIV;
			ST_TFIN: state_d = ST_DONE;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3:  state_d = ST_P4;
			ST_P4:  state_d = ST_P5;
			ST_P5:  state_d = ST_P6;
			ST_P6:  state_d = ST_P7;
			ST_P7:  state_d = ST_P8;
			ST_P8:  state_d = (b4_q == 0) ? ST_DONE : ST_DIV;
			ST_DIV: if (cnt_q == 5'd31) begin
				state_d = (cmd_q == CMD_PRESS) ? ST_PQ : ST_TFIN;
			end
			ST_PQ:  state_d = ST_P9;
			ST_P9:  state_d = ST_P10;
			ST_P10: state_d = ST_P11;
			ST_P11: state_d = ST_DONE;
			ST_DONE: if (out_free) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers and kept B5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q  <= '0;
			ac2_q  <= '0;
			ac3_q  <= '0;
			ac4_q  <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
			b5_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_AC1:    ac1_q  <= cfg_wdata[15:0];
					CFG_AC2:    ac2_q  <= cfg_wdata[15:0];
					CFG_AC3:    ac3_q  <= cfg_wdata[15:0];
					CFG_AC4:    ac4_q  <= cfg_wdata[15:0];
					CFG_AC5AC6: ac56_q <= cfg_wdata;
					CFG_B1B2:   b12_q  <= cfg_wdata;
					CFG_MCMD:   mcmd_q <= cfg_wdata;
					CFG_OSS:    oss_q  <= cfg_wdata[1:0];
					default: ;
				endcase
			end
			if (state_q == ST_TFIN) begin
				b5_q <= b5_t;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (in_fire) begin
				cmd_q <= in_ch.cmd;
				raw_q <= in_ch.raw_reading;
				err_q <= 1'b0;
			end
			ST_T1: x1_q <= sprod >>> 15;
			ST_T2: begin
				// a zero divisor drops the quotient term
				rem_q  <= '0;
				cnt_q  <= '0;
				quo_q  <= mc_sh[31] ? -mc_sh : mc_sh;
				dden_q <= den[31] ? -den : den;
				neg_q  <= mc_sh[31] ^ den[31];
				if (den == 0) begin
					err_q <= 1'b1;
					quo_q <= '0;
					neg_q <= 1'b0;
				end
			end
			ST_TFIN: res_q <= (b5_t + 32'sd8) >>> 4;
			ST_P1: sq_q <= sprod >>> 12;
			ST_P2: t1_q <= sprod >>> 11;
			ST_P3: t1_q <= t1_q + (sprod >>> 11);
			ST_P4: b3_q <= (sprod + 32'sd2) >>> 2;
			ST_P5: t1_q <= sprod >>> 13;
			ST_P6: t1_q <= (t1_q + (sprod >>> 16) + 32'sd2) >>> 2;
			ST_P7: b4_q <= prod >> 15;
			ST_P8: begin
				rem_q  <= '0;
				cnt_q  <= '0;
				dden_q <= b4_q;
				neg_q  <= 1'b0;
				big_q  <= prod >= B7_TOPBIT;
				quo_q  <= (prod >= B7_TOPBIT) ? prod : (prod << 1);
				if (b4_q == 0) begin
					err_q <= 1'b1;
					res_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= ge ? 32'(rem_sh - {1'b0, dden_q}) : rem_sh[31:0];
				quo_q <= {quo_q[30:0], ge};
				cnt_q <= cnt_q + 5'd1;
			end
			ST_PQ: p_q <= big_q ? (quo_q << 1) : quo_q;
			ST_P9: t1_q <= sprod;
			ST_P10: t1_q <= sprod >>> 16;
			ST_P11: res_q <= p_q + ((t1_q + (sprod >>> 16) + P_C3) >>> 4);
			default: ;
		endcase
	end

	// Output register with saturation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_kind_q <= cmd_q;
			if (res_q > OUT_MAX) begin
				out_val_q <= OUT_MAX[VAL_W-1:0];
				out_err_q <= 1'b1;
			end else if (res_q < OUT_MIN) begin
				out_val_q <= OUT_MIN[VAL_W-1:0];
				out_err_q <= 1'b1;
			end else begin
				out_val_q <= res_q[VAL_W-1:0];
				out_err_q <= err_q;
			end
		end
	end

	assign out_ch.valid             = out_valid_q;
	assign out_ch.reading_kind      = out_kind_q;
	assign out_ch.compensated_value = out_val_q;
	assign out_ch.math_error        = out_err_q;

	`ASSERT_CLK(a_busy_after_accept, in_fire |=> state_q != ST_IDLE)
	`ASSERT_CLK(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
	`ASSERT_CLK(a_tzero_flags, (state_q == ST_T2 && den == 0) |=> err_q)
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |-> state_q == ST_IDLE)

endmodule
